// ===== src/ascii_integer_parser_core_assert.svh =====
// Assertion macros for the ASCII integer parser.
`ifndef ASCII_INTEGER_PARSER_CORE_ASSERT_SVH
`define ASCII_INTEGER_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AIP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define AIP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define AIP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define AIP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== src/aip_pkg.sv =====
// Shared types and constants of the ASCII integer parser.
`default_nettype none
package aip_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // low nibble of a-f / A-F plus this gives 10..15
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

  localparam logic [1:0] FORM_DEC  = 2'd0;
  localparam logic [1:0] FORM_HEX  = 2'd1;
  localparam logic [1:0] FORM_CHAR = 2'd2;
  localparam logic [1:0] FORM_RSVD = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0] chr;
    logic       first;
    logic       minus;
    logic       quote;
    logic       xchar;
    logic       dec;
    logic       hex;
    logic [3:0] digit;
  } aip_item_t;

endpackage
`default_nettype wire

// ===== src/aip_front.sv =====
// Front end: accepts character beats and classifies them for the back end.
`default_nettype none
module aip_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        character,
  input  logic              first_char,
  input  logic              fifo_full,
  output logic              push,
  output aip_pkg::aip_item_t item
);
  import aip_pkg::*;

  logic is_lower;
  logic is_upper;

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    is_lower   = (character >= CH_LA) && (character <= CH_LF);
    is_upper   = (character >= CH_UA) && (character <= CH_UF);
    item.chr   = character;
    item.first = first_char;
    item.minus = (character == CH_MINUS);
    item.quote = (character == CH_QUOTE);
    item.xchar = (character == CH_LX) || (character == CH_UX);
    item.dec   = (character >= CH_ZERO) && (character <= CH_NINE);
    item.hex   = item.dec || is_lower || is_upper;
    item.digit = item.dec ? character[3:0] : character[3:0] + HEX_ALPHA_OFS;
  end

endmodule
`default_nettype wire

// ===== src/aip_fifo.sv =====
// Short queue of classified characters between front and back end.
`default_nettype none
module aip_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  aip_pkg::aip_item_t wr_item,
  input  logic               pop,
  output aip_pkg::aip_item_t rd_item,
  output logic               full,
  output logic               empty
);
  import aip_pkg::*;

  aip_item_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr;
  logic [FIFO_AW-1:0]    rd_ptr;
  logic [FIFO_AW:0]      count;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/aip_back.sv =====
// Back end: parse state machine, accumulator and output register.
`default_nettype none
module aip_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fifo_empty,
  input  aip_pkg::aip_item_t item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        number,
  output logic [1:0]         number_form
);
  import aip_pkg::*;

  localparam int EXT_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_START = 7'b0000010,
    PH_LEAD  = 7'b0000100,
    PH_ZERO  = 7'b0001000,
    PH_HEX   = 7'b0010000,
    PH_DEC   = 7'b0100000,
    PH_QUOTE = 7'b1000000
  } phase_t;

  phase_t                phase, phase_next, ph;
  logic                  negative, negative_next;
  logic [VALUE_BITS-1:0] accumulator, accumulator_next, acc;
  logic                  emit;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] sval;
  logic [EXT_W-1:0]      sext;
  logic [1:0]            form;
  logic [VALUE_BITS-1:0] digit_ext;

  // the output register is free or drains this cycle
  assign pop = !fifo_empty && (!out_valid || out_ready);

  // next-state logic: optional sign, leading byte, digit accumulation and result
  always_comb begin
    ph               = item.first ? PH_START : phase;
    negative_next    = item.first ? 1'b0 : negative;
    acc              = item.first ? '0 : accumulator;
    digit_ext        = VALUE_BITS'(item.digit);
    phase_next       = ph;
    accumulator_next = acc;
    emit             = 1'b0;
    mag              = '0;
    form             = FORM_DEC;
    unique case (ph)
      PH_START, PH_LEAD: begin
        if (ph == PH_START && item.minus) begin
          negative_next = 1'b1;
          phase_next    = PH_LEAD;
        end else if (item.dec && item.digit == 4'd0) begin
          accumulator_next = '0;
          phase_next       = PH_ZERO;
        end else if (item.quote) begin
          phase_next = PH_QUOTE;
        end else if (item.dec) begin
          accumulator_next = digit_ext;
          phase_next       = PH_DEC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (item.xchar) begin
          accumulator_next = '0;
          phase_next       = PH_HEX;
        end else if (item.dec) begin
          accumulator_next = digit_ext;
          phase_next       = PH_DEC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HEX: begin
        if (item.hex) begin
          accumulator_next = (acc << 4) + digit_ext;
        end else begin
          emit = 1'b1;
          mag  = acc;
          form = FORM_HEX;
        end
      end
      PH_DEC: begin
        if (item.dec) begin
          accumulator_next = (acc << 3) + (acc << 1) + digit_ext;
        end else begin
          emit = 1'b1;
          mag  = acc;
        end
      end
      PH_QUOTE: begin
        emit = 1'b1;
        mag  = VALUE_BITS'($signed(item.chr));
        form = FORM_CHAR;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (emit) begin
      phase_next = PH_IDLE;
    end
    sval = negative_next ? (VALUE_BITS'(0) - mag) : mag;
    sext = EXT_W'($signed(sval));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      negative    <= 1'b0;
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      number      <= sext[31:0];
      number_form <= form;
    end
  end

endmodule
`default_nettype wire

// ===== src/ascii_integer_parser_core.sv =====
// ASCII decimal / hex / character-literal integer parser, top level.
// Input stream: one text byte per beat in s_axis_tdata[7:0]; s_axis_tuser
//   is set on the first byte of a string and restarts the parse.
// Accepted syntax: optional '-', then "0x"/"0X" and hex digits, a quote and
//   one byte taken as signed 8-bit, or decimal digits. The first byte that
//   fits none of these ends the number; bytes after it are dropped until
//   the next first-byte flag.
// Output stream: one beat per finished number, value in tdata[31:0] (wraps
//   modulo 2^VALUE_BITS, sign-extended to 32 bits) and form in tdata[33:32]
//   (0 decimal, 1 hex, 2 character).
// Throughput: one byte per cycle while no result waits on m_axis_tready. The
//   terminating byte passes through the 4-entry queue, and the result is then
//   held in the output register. The per-byte update is made of shifts and adds.
// Reset (rst, synchronous): empties the queue, parser goes idle.
// Stall: while a result waits on m_axis_tready the back end holds, the
//   queue fills, and s_axis_tready drops once it holds four bytes.
`default_nettype none
`include "ascii_integer_parser_core_assert.svh"
module ascii_integer_parser_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] first_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] number, [33:32] number_form, rest zero
);
  import aip_pkg::*;

  aip_item_t   front_item;
  aip_item_t   back_item;
  logic        fifo_push;
  logic        fifo_pop;
  logic        fifo_full;
  logic        fifo_empty;
  logic [31:0] number;
  logic [1:0]  number_form;

  aip_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .character  (s_axis_tdata),
    .first_char (s_axis_tuser),
    .fifo_full  (fifo_full),
    .push       (fifo_push),
    .item       (front_item)
  );

  aip_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (fifo_push),
    .wr_item (front_item),
    .pop     (fifo_pop),
    .rd_item (back_item),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  aip_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_empty  (fifo_empty),
    .item        (back_item),
    .pop         (fifo_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .number      (number),
    .number_form (number_form)
  );

  assign m_axis_tdata = {6'd0, number_form, number};

  `AIP_ASSERT_IMP(a_no_overwrite, clk, rst, fifo_pop && m_axis_tvalid, m_axis_tready, "result overwritten while stalled")
  `AIP_ASSERT_IMP(a_pop_nonempty, clk, rst, fifo_pop, !fifo_empty, "pop from empty queue")
  `AIP_ASSERT_NEXT(a_empty_holds, clk, rst, fifo_empty && !fifo_push, fifo_empty, "queue filled without a push")
  `AIP_ASSERT_IMP(a_form_valid, clk, rst, m_axis_tvalid, m_axis_tdata[33:32] != FORM_RSVD, "reserved number form")

endmodule
`default_nettype wire
